### hdl/qbim_pkg.sv
package qbim_pkg;

  localparam int unsigned MAX_BOXES_DEF = 64;
  localparam int unsigned RESET_BOXES   = 64;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned POS_W         = 7;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CLEAR  = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_MERGE  = 5'b01000,
    ST_FINISH = 5'b10000
  } qbim_state_t;

  // Unsigned add that sticks at all ones on overflow
  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W] ? {DATA_W{1'b1}} : s[DATA_W-1:0];
  endfunction

endpackage

### hdl/quantile_box_insert_merge_unit.sv
// Quantile box summary: insert a copy of one box, then merge the cheapest
// neighboring pair, keeping box_count boxes of (height, gap).
//
// Channels: cfg_* writes box_count (clamped to 1..MAX_BOXES) and clears the
// boxes. in_* carries one insert position per item. out_* returns one item
// per input item: the largest height after the step and the merge index.
// All channels use valid/ready; an item moves when both are high.
//
// Item flow: one item at a time; a new item is accepted only in the idle state,
// after the previous result has moved to the output register. The single read
// port of the box memory sets the pace: one pass of k reads finds the first
// minimum height+gap, and a second pass of k+1 reads streams the rebuilt boxes
// back in place.
//
// Reset and box_count writes start a clearing pass over all MAX_BOXES memory
// entries; no input item is taken until it ends.
//
// A stalled receiver does not block the next input: the result sits in an
// output register while the next item is accepted and worked on; only the
// final hand-off of that next result waits for the register to free up.
module quantile_box_insert_merge_unit #(
  parameter int unsigned MAX_BOXES = qbim_pkg::MAX_BOXES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [qbim_pkg::POS_W-1:0]   cfg_box_count,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [qbim_pkg::POS_W-1:0]   in_insert_position,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [qbim_pkg::DATA_W-1:0]  out_max_height,
  output logic [qbim_pkg::POS_W-1:0]   out_merge_index
);
  import qbim_pkg::*;

  localparam int unsigned AW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned JW   = $clog2(MAX_BOXES + 2);
  localparam int unsigned WW   = (JW > POS_W) ? JW : POS_W;
  localparam int unsigned KRST = (RESET_BOXES < MAX_BOXES) ? RESET_BOXES : MAX_BOXES;
  localparam int unsigned MW   = 2 * DATA_W;

  // Box memory: {height, gap}, one read and one write port
  logic [MW-1:0]     box_mem_r [MAX_BOXES];
  logic [MW-1:0]     rd_data_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [AW-1:0]     mem_ra;
  logic [DATA_W-1:0] wd_h;
  logic [DATA_W-1:0] wd_g;

  qbim_state_t       state_r, state_nxt;
  logic [AW-1:0]     clr_addr_r;
  logic [JW-1:0]     k_r;
  logic [JW-1:0]     p_r;
  logic [JW-1:0]     rj_r;       // index of the box being read
  logic              issue_r;
  logic              rd_valid_r;
  logic [JW-1:0]     rd_j_r;     // index of the box on the read data
  logic [DATA_W-1:0] best_r;
  logic [JW-1:0]     mi_r;
  logic [DATA_W-1:0] gsave_r;
  logic [DATA_W-1:0] maxh_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_h_r;
  logic [POS_W-1:0]  out_idx_r;

  logic              cfg_fire, in_fire, clr_last, last_data, out_free;
  logic [WW-1:0]     cfg_ext, pos_ext, k_ext;
  logic [JW-1:0]     k_cfg, p_clamp;
  logic [DATA_W-1:0] w_h, w_g, w_sum;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign in_fire   = in_valid & in_ready;
  assign clr_last  = (clr_addr_r == AW'(MAX_BOXES - 1));
  assign last_data = rd_valid_r && (rd_j_r == k_r + 1'b1);
  assign out_free  = !out_valid_r || out_ready;

  // Clamp the box count and the insert position
  always_comb begin
    cfg_ext = WW'(cfg_box_count);
    if (cfg_ext == '0) begin
      k_cfg = JW'(1);
    end else if (cfg_ext > WW'(MAX_BOXES)) begin
      k_cfg = JW'(MAX_BOXES);
    end else begin
      k_cfg = JW'(cfg_ext);
    end
    pos_ext = WW'(in_insert_position);
    k_ext   = WW'(k_r);
    if (pos_ext == '0) begin
      p_clamp = JW'(1);
    end else if (pos_ext > k_ext) begin
      p_clamp = k_r;
    end else begin
      p_clamp = JW'(pos_ext);
    end
  end

  // Box j of the k+1 working boxes: the copy sits right after box p
  always_comb begin
    if (rj_r <= p_r) begin
      mem_ra = AW'(rj_r - 1'b1);
    end else if (rj_r == p_r + 1'b1) begin
      mem_ra = AW'(p_r - 1'b1);
    end else begin
      mem_ra = AW'(rj_r - 2'd2);
    end
  end

  assign w_h   = rd_data_r[MW-1:DATA_W];
  assign w_g   = (rd_j_r == p_r + 1'b1) ? DATA_W'(1) : rd_data_r[DATA_W-1:0];
  assign w_sum = sat_add(w_h, w_g);

  // Write port: clearing pass, or the in-place rebuild during the merge pass.
  // Writes trail the reads, so no address is read after it is rewritten.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    wd_h   = '0;
    wd_g   = '0;
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
      wd_g   = (clr_addr_r == '0) ? '0 : DATA_W'(1);
    end else if (state_r == ST_MERGE && rd_valid_r) begin
      if (rd_j_r < mi_r - 1'b1) begin
        // ahead of the merged pair: copy
        mem_we = 1'b1;
        mem_wa = AW'(rd_j_r - 1'b1);
        wd_h   = w_h;
        wd_g   = w_g;
      end else if (rd_j_r == mi_r) begin
        // merged box
        mem_we = 1'b1;
        mem_wa = AW'(mi_r - 2'd2);
        wd_h   = best_r;
        wd_g   = gsave_r;
      end else if (rd_j_r - 1'b1 == mi_r) begin
        // box after the merge absorbs the merged gap
        mem_we = 1'b1;
        mem_wa = AW'(mi_r - 1'b1);
        wd_h   = w_h;
        wd_g   = sat_add(w_g, gsave_r);
      end else if (rd_j_r - 1'b1 > mi_r) begin
        // tail: move down by one
        mem_we = 1'b1;
        mem_wa = AW'(rd_j_r - 2'd2);
        wd_h   = w_h;
        wd_g   = w_g;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      box_mem_r[mem_wa] <= {wd_h, wd_g};
    end
    rd_data_r <= box_mem_r[mem_ra];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_fire) state_nxt = ST_SCAN;
      ST_SCAN:   if (last_data) state_nxt = ST_MERGE;
      ST_MERGE:  if (last_data) state_nxt = ST_FINISH;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
    if (cfg_fire) begin
      state_nxt = ST_CLEAR;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      k_r         <= JW'(KRST);
      issue_r     <= 1'b0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_valid_r <= issue_r && !cfg_fire;

      if (cfg_fire) begin
        k_r        <= k_cfg;
        clr_addr_r <= '0;
      end else if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end

      // issue reads: boxes 2..k+1 for the scan, 1..k+1 for the merge
      if (cfg_fire) begin
        issue_r <= 1'b0;
      end else if (in_fire) begin
        issue_r <= 1'b1;
      end else if (state_r == ST_SCAN && last_data) begin
        issue_r <= 1'b1;
      end else if (issue_r && rj_r == k_r + 1'b1) begin
        issue_r <= 1'b0;
      end

      if (state_r == ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rd_j_r <= rj_r;
    if (in_fire) begin
      p_r  <= p_clamp;
      rj_r <= JW'(2);
    end else if (state_r == ST_SCAN && last_data) begin
      rj_r <= JW'(1);
    end else if (issue_r && rj_r != k_r + 1'b1) begin
      rj_r <= rj_r + 1'b1;
    end

    // keep the first smallest height+gap
    if (state_r == ST_SCAN && rd_valid_r) begin
      if (rd_j_r == JW'(2) || w_sum < best_r) begin
        best_r <= w_sum;
        mi_r   <= rd_j_r;
      end
    end

    // hold gap of box mi-1, then gap of box mi
    if (state_r == ST_MERGE && rd_valid_r &&
        (rd_j_r == mi_r - 1'b1 || rd_j_r == mi_r)) begin
      gsave_r <= w_g;
    end

    if (state_r == ST_SCAN && last_data) begin
      maxh_r <= '0;
    end else if (state_r == ST_MERGE && mem_we && wd_h > maxh_r) begin
      maxh_r <= wd_h;
    end

    if (state_r == ST_FINISH && out_free) begin
      out_h_r   <= maxh_r;
      out_idx_r <= POS_W'(mi_r - 1'b1);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_max_height  = out_h_r;
  assign out_merge_index = out_idx_r;

  // Rebuild writes stay inside the k live boxes
  a_merge_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE && mem_we) |-> (JW'(mem_wa) < k_r))
    else $error("merge write beyond box count");

  // Merge position lies in 2..k+1 for the whole merge pass
  a_mi_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE) |-> (mi_r >= JW'(2) && mi_r <= k_r + 1'b1))
    else $error("merge position out of range");

  // A result appears only as an item finishes
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result without finished item");

  // An accepted item starts the scan pass
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !cfg_fire) |=> (state_r == ST_SCAN && issue_r))
    else $error("accepted item did not start scan");

endmodule
